@@ hdl/pgd_pkg.sv @@
// shared types, constants and helpers for the periodic grid diffusion block
package pgd_pkg;

	localparam int VAL_W   = 15;
	localparam int ROW_W   = 3;
	localparam int GS_W    = 4;
	localparam int LC_W    = 16;
	localparam int TW_W    = 17;
	localparam int SW_W    = 15;
	localparam int NB_W    = 17;
	localparam int PROD_W  = 32;
	localparam int LIN_W   = ROW_W + GS_W;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [VAL_W-1:0] ONE_Q14     = 15'd16384;
	localparam logic [VAL_W-1:0] TOP_Q14     = 15'd32767;
	localparam logic [TW_W-1:0]  ONE_Q16     = 17'd65536;
	localparam logic [SW_W-1:0]  QUARTER_Q16 = 15'd16384;
	localparam logic [GS_W-1:0]  MIN_SIDE    = 4'd3;

	typedef enum logic [1:0] {
		REG_GRID_SIZE,
		REG_LAYER_COUNT,
		REG_TEMPORAL,
		REG_SPATIAL
	} reg_idx_t;

	typedef struct packed {
		logic [GS_W-1:0] grid_size;
		logic [LC_W-1:0] layer_count;
		logic [TW_W-1:0] temporal_weight;
		logic [SW_W-1:0] spatial_weight;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_BLEND_RD,
		OP_BLEND_MUL,
		OP_BLEND_WR,
		OP_SM_RD0,
		OP_SM_RD1,
		OP_SM_RD2,
		OP_SM_ACC,
		OP_SM_MUL,
		OP_SM_WR,
		OP_COPY,
		OP_COPY_END,
		OP_EMIT_RD,
		OP_EMIT_LD,
		OP_FILL
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic             last;
	} dp_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BL_RD,
		ST_BL_MUL,
		ST_BL_WR,
		ST_SM_RD0,
		ST_SM_RD1,
		ST_SM_RD2,
		ST_SM_ACC,
		ST_SM_MUL,
		ST_SM_WR,
		ST_CP,
		ST_CP_END,
		ST_EM_RD,
		ST_EM_LD,
		ST_FILL
	} ctrl_state_t;

	// side of the grid actually used, clamped to [3, max_side]
	function automatic logic [GS_W-1:0] side_clamp(input logic [GS_W-1:0] gs,
			input logic [GS_W-1:0] max_side);
		logic [GS_W-1:0] s;
		s = gs;
		if (gs < MIN_SIDE) begin
			s = MIN_SIDE;
		end else if (gs > max_side) begin
			s = max_side;
		end
		return s;
	endfunction

endpackage

@@ hdl/pgd_ifs.sv @@
// valid/ready channel interfaces for noise samples and emitted cells
interface pgd_noise_if
	import pgd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] noise_sample;

	modport source (output valid, output noise_sample, input ready);
	modport sink (input valid, input noise_sample, output ready);
endinterface

interface pgd_cell_if
	import pgd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] cell_value;
	logic [ROW_W-1:0] cell_row;
	logic [ROW_W-1:0] cell_col;
	logic             last_cell;

	modport source (output valid, output cell_value, output cell_row, output cell_col,
		output last_cell, input ready);
	modport sink (input valid, input cell_value, input cell_row, input cell_col,
		input last_cell, output ready);
endinterface

@@ hdl/pgd_regs.sv @@
// apb configuration registers
module pgd_regs
	import pgd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_size       <= 4'd8;
			cfg_q.layer_count     <= 16'd1;
			cfg_q.temporal_weight <= '0;
			cfg_q.spatial_weight  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_GRID_SIZE:   cfg_q.grid_size       <= pwdata[GS_W-1:0];
				REG_LAYER_COUNT: cfg_q.layer_count     <= pwdata[LC_W-1:0];
				REG_TEMPORAL:    cfg_q.temporal_weight <= pwdata[TW_W-1:0];
				REG_SPATIAL:     cfg_q.spatial_weight  <= pwdata[SW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GRID_SIZE:   prdata = APB_DW'(cfg_q.grid_size);
			REG_LAYER_COUNT: prdata = APB_DW'(cfg_q.layer_count);
			REG_TEMPORAL:    prdata = APB_DW'(cfg_q.temporal_weight);
			REG_SPATIAL:     prdata = APB_DW'(cfg_q.spatial_weight);
			default:         prdata = '0;
		endcase
	end

endmodule

@@ hdl/pgd_dpath.sv @@
// datapath: grid and scratch memories, shared blend/smooth multipliers, output register
module pgd_dpath
	import pgd_pkg::*;
#(
	parameter int MAX_GRID = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cfg_t                                    cfg,
	input  dp_cmd_t                                 cmd,
	input  logic [$clog2(MAX_GRID*MAX_GRID)-1:0]    addr,
	input  logic                                    take,
	input  logic [VAL_W-1:0]                        noise_sample,
	input  logic                                    out_ready,
	output logic                                    out_valid,
	output logic [VAL_W-1:0]                        cell_value,
	output logic [ROW_W-1:0]                        cell_row,
	output logic [ROW_W-1:0]                        cell_col,
	output logic                                    last_cell,
	output logic                                    out_free
);

	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int AW    = $clog2(DEPTH);

	logic [VAL_W-1:0] grid_mem   [DEPTH];
	logic [VAL_W-1:0] smooth_mem [DEPTH];
	logic [DEPTH-1:0] grid_vld_q;

	logic [GS_W-1:0]  n;
	logic [ROW_W-1:0] nm1, up, dn, lf, rt;
	logic [AW-1:0]    addr_a, addr_b, addr_c;
	logic             rd_a_en, rd_b_en;
	logic [VAL_W-1:0] rda_raw_q, rdb_raw_q, sm_rd_q;
	logic             rda_vld_q, rdb_vld_q;
	logic [VAL_W-1:0] rd_a, rd_b;

	logic             g_we;
	logic [AW-1:0]    g_waddr;
	logic [VAL_W-1:0] g_wdata;
	logic [AW-1:0]    copy_addr_q;
	logic             copy_pend_q;

	logic [VAL_W-1:0] sample_q, centre_q;
	logic [NB_W-1:0]  nb_q;
	logic [TW_W-1:0]  at, cw, w1, w2;
	logic [SW_W-1:0]  as;
	logic [VAL_W-1:0] x1;
	logic [NB_W-1:0]  x2;
	logic [TW_W+NB_W-1:0] prod2;
	logic [PROD_W-1:0] p1_q, p2_q;
	logic [PROD_W:0]   sum;
	logic [NB_W-1:0]   rnd;
	logic [VAL_W-1:0]  res;

	logic             out_valid_q;

	function automatic logic [AW-1:0] lin(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] c, input logic [GS_W-1:0] side);
		logic [LIN_W-1:0] v;
		v = LIN_W'(r) * LIN_W'(side) + LIN_W'(c);
		return v[AW-1:0];
	endfunction

	// wraparound neighbours
	always_comb begin
		n   = side_clamp(cfg.grid_size, GS_W'(MAX_GRID));
		nm1 = ROW_W'(n - 4'd1);
		up  = (cmd.row == '0) ? nm1 : cmd.row - 3'd1;
		dn  = ((GS_W'(cmd.row) + 4'd1) == n) ? '0 : cmd.row + 3'd1;
		lf  = (cmd.col == '0) ? nm1 : cmd.col - 3'd1;
		rt  = ((GS_W'(cmd.col) + 4'd1) == n) ? '0 : cmd.col + 3'd1;
		addr_c = lin(cmd.row, cmd.col, n);
	end

	always_comb begin
		addr_a  = addr_c;
		addr_b  = lin(up, cmd.col, n);
		rd_a_en = 1'b0;
		rd_b_en = 1'b0;
		case (cmd.op) inside
			OP_BLEND_RD: begin
				addr_a  = addr;
				rd_a_en = 1'b1;
			end
			OP_SM_RD0: begin
				rd_a_en = 1'b1;
				rd_b_en = 1'b1;
			end
			OP_SM_RD1: begin
				addr_a  = lin(dn, cmd.col, n);
				addr_b  = lin(cmd.row, lf, n);
				rd_a_en = 1'b1;
				rd_b_en = 1'b1;
			end
			OP_SM_RD2: begin
				addr_a  = lin(cmd.row, rt, n);
				rd_a_en = 1'b1;
			end
			OP_EMIT_RD: begin
				rd_a_en = 1'b1;
			end
			default: ;
		endcase
	end

	// cells never written since reset or the last fill read as 1.0
	assign rd_a = rda_vld_q ? rda_raw_q : ONE_Q14;
	assign rd_b = rdb_vld_q ? rdb_raw_q : ONE_Q14;

	always_comb begin
		g_we    = 1'b0;
		g_waddr = copy_addr_q;
		g_wdata = sm_rd_q;
		if (cmd.op == OP_BLEND_WR) begin
			g_we    = 1'b1;
			g_waddr = addr;
			g_wdata = res;
		end else if ((cmd.op == OP_COPY || cmd.op == OP_COPY_END) && copy_pend_q) begin
			g_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rda_raw_q <= grid_mem[addr_a];
		end
		if (rd_b_en) begin
			rdb_raw_q <= grid_mem[addr_b];
		end
		if (g_we) begin
			grid_mem[g_waddr] <= g_wdata;
		end
		if (cmd.op == OP_COPY) begin
			sm_rd_q <= smooth_mem[addr];
		end
		if (cmd.op == OP_SM_WR) begin
			smooth_mem[addr_c] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_vld_q  <= '0;
			rda_vld_q   <= 1'b0;
			rdb_vld_q   <= 1'b0;
			copy_pend_q <= 1'b0;
			copy_addr_q <= '0;
		end else begin
			if (rd_a_en) begin
				rda_vld_q <= grid_vld_q[addr_a];
			end
			if (rd_b_en) begin
				rdb_vld_q <= grid_vld_q[addr_b];
			end
			if (cmd.op == OP_FILL) begin
				grid_vld_q <= '0;
			end else if (g_we) begin
				grid_vld_q[g_waddr] <= 1'b1;
			end
			if (cmd.op == OP_COPY) begin
				copy_pend_q <= 1'b1;
				copy_addr_q <= addr;
			end else if (cmd.op == OP_COPY_END) begin
				copy_pend_q <= 1'b0;
			end
		end
	end

	// weights and multiplier operands
	always_comb begin
		at = (cfg.temporal_weight > ONE_Q16) ? ONE_Q16 : cfg.temporal_weight;
		as = (cfg.spatial_weight > QUARTER_Q16) ? QUARTER_Q16 : cfg.spatial_weight;
		cw = ONE_Q16 - {as, 2'b00};
		if (cmd.op == OP_SM_MUL) begin
			w1 = cw;
			x1 = centre_q;
			w2 = TW_W'(as);
			x2 = nb_q;
		end else begin
			w1 = ONE_Q16 - at;
			x1 = rd_a;
			w2 = at;
			x2 = NB_W'(sample_q);
		end
		prod2 = w2 * x2;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= noise_sample;
		end
		case (cmd.op)
			OP_SM_RD1: begin
				centre_q <= rd_a;
				nb_q     <= NB_W'(rd_b);
			end
			OP_SM_RD2: nb_q <= nb_q + NB_W'(rd_a) + NB_W'(rd_b);
			OP_SM_ACC: nb_q <= nb_q + NB_W'(rd_a);
			default: ;
		endcase
		if (cmd.op == OP_BLEND_MUL || cmd.op == OP_SM_MUL) begin
			p1_q <= w1 * x1;
			p2_q <= prod2[PROD_W-1:0];
		end
	end

	// round half up to q1.14 and saturate
	always_comb begin
		sum = (PROD_W+1)'(p1_q) + (PROD_W+1)'(p2_q) + (PROD_W+1)'(32768);
		rnd = sum[PROD_W:16];
		res = (rnd > NB_W'(TOP_Q14)) ? TOP_Q14 : rnd[VAL_W-1:0];
	end

	// output register
	assign out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT_LD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT_LD) begin
			cell_value <= rd_a;
			cell_row   <= cmd.row;
			cell_col   <= cmd.col;
			last_cell  <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/pgd_ctrl.sv @@
// controller: sequences blend, smoothing sweep, copy-back, emission and fill
module pgd_ctrl
	import pgd_pkg::*;
#(
	parameter int MAX_GRID = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cfg_t                                 cfg,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 out_free,
	output dp_cmd_t                              cmd,
	output logic [$clog2(MAX_GRID*MAX_GRID)-1:0] addr
);

	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	ctrl_state_t      state_q, state_d;
	logic [AW-1:0]    pos_q, cell_pos_q, k_q;
	logic [LC_W-1:0]  layer_pos_q;
	logic [ROW_W-1:0] row_q, col_q;

	logic [GS_W-1:0]  n;
	logic [ROW_W-1:0] nm1;
	logic [7:0]       sq;
	logic [CW-1:0]    cells;
	logic [LC_W-1:0]  layers;
	logic             accept, layer_end, more_layers, grid_last, copy_last;

	always_comb begin
		n           = side_clamp(cfg.grid_size, GS_W'(MAX_GRID));
		nm1         = ROW_W'(n - 4'd1);
		sq          = 8'(n) * 8'(n);
		cells       = CW'(sq);
		layers      = (cfg.layer_count == '0) ? 16'd1 : cfg.layer_count;
		accept      = in_valid & in_ready;
		layer_end   = (CW'(pos_q) + CW'(1)) >= cells;
		more_layers = (17'(layer_pos_q) + 17'd1) < 17'(layers);
		grid_last   = (row_q == nm1) && (col_q == nm1);
		copy_last   = k_q == AW'(DEPTH - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.op   = OP_NOP;
		cmd.row  = row_q;
		cmd.col  = col_q;
		cmd.last = grid_last;
		addr     = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_BL_RD;
				end
			end
			ST_BL_RD: begin
				cmd.op  = OP_BLEND_RD;
				state_d = ST_BL_MUL;
			end
			ST_BL_MUL: begin
				cmd.op  = OP_BLEND_MUL;
				state_d = ST_BL_WR;
			end
			ST_BL_WR: begin
				cmd.op  = OP_BLEND_WR;
				state_d = layer_end ? ST_SM_RD0 : ST_IDLE;
			end
			ST_SM_RD0: begin
				cmd.op  = OP_SM_RD0;
				state_d = ST_SM_RD1;
			end
			ST_SM_RD1: begin
				cmd.op  = OP_SM_RD1;
				state_d = ST_SM_RD2;
			end
			ST_SM_RD2: begin
				cmd.op  = OP_SM_RD2;
				state_d = ST_SM_ACC;
			end
			ST_SM_ACC: begin
				cmd.op  = OP_SM_ACC;
				state_d = ST_SM_MUL;
			end
			ST_SM_MUL: begin
				cmd.op  = OP_SM_MUL;
				state_d = ST_SM_WR;
			end
			ST_SM_WR: begin
				cmd.op  = OP_SM_WR;
				state_d = grid_last ? ST_CP : ST_SM_RD0;
			end
			ST_CP: begin
				cmd.op  = OP_COPY;
				addr    = k_q;
				state_d = copy_last ? ST_CP_END : ST_CP;
			end
			ST_CP_END: begin
				cmd.op  = OP_COPY_END;
				state_d = more_layers ? ST_IDLE : ST_EM_RD;
			end
			ST_EM_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = ST_EM_LD;
			end
			ST_EM_LD: begin
				if (out_free) begin
					cmd.op  = OP_EMIT_LD;
					state_d = grid_last ? ST_FILL : ST_EM_RD;
				end
			end
			ST_FILL: begin
				cmd.op  = OP_FILL;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cell_pos_q  <= '0;
			k_q         <= '0;
			layer_pos_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// a position left beyond a shrunk grid restarts the layer
						pos_q <= (CW'(cell_pos_q) < cells) ? cell_pos_q : '0;
					end
				end
				ST_BL_WR: begin
					row_q <= '0;
					col_q <= '0;
					cell_pos_q <= layer_end ? '0 : pos_q + AW'(1);
				end
				ST_SM_WR: begin
					k_q <= '0;
					if (col_q == nm1) begin
						col_q <= '0;
						row_q <= row_q + 3'd1;
					end else begin
						col_q <= col_q + 3'd1;
					end
				end
				ST_CP: k_q <= k_q + AW'(1);
				ST_CP_END: begin
					row_q <= '0;
					col_q <= '0;
					if (more_layers) begin
						layer_pos_q <= layer_pos_q + 16'd1;
					end
				end
				ST_EM_LD: begin
					if (out_free) begin
						if (col_q == nm1) begin
							col_q <= '0;
							row_q <= row_q + 3'd1;
						end else begin
							col_q <= col_q + 3'd1;
						end
					end
				end
				ST_FILL: layer_pos_q <= '0;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/periodic_grid_diffusion_layers_core.sv @@
// top level of the periodic grid diffusion block
//
//  channel  | direction | words                     | handshake
//  ---------+-----------+---------------------------+--------------------
//  noise    | in        | noise_sample              | valid/ready
//  result   | out       | cell_value/row/col/last   | valid/ready
//  apb      | in        | grid_size .. spatial_wgt  | psel/penable/pready
//
// a sample passes through accept, grid read, multiply, round and write back
// a layer end adds a smoothing sweep (five neighbour reads over the two grid read
// ports) and a copy-back of all MAX_GRID*MAX_GRID cells
// a run end adds emission (a read and a load per cell) plus a fill, longer
// while the result register stalls; no clearing pass, grid reads 1.0 after reset
module periodic_grid_diffusion_layers_core
	import pgd_pkg::*;
#(
	parameter int MAX_GRID = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	pgd_noise_if.sink         noise,
	pgd_cell_if.source        result
);

	localparam int AW = $clog2(MAX_GRID * MAX_GRID);

	cfg_t          cfg;
	dp_cmd_t       cmd;
	logic [AW-1:0] addr;
	logic          out_free;
	logic          take;

	assign pready = 1'b1;
	assign take   = noise.valid & noise.ready;

	pgd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	pgd_ctrl #(.MAX_GRID(MAX_GRID)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (noise.valid),
		.in_ready (noise.ready),
		.out_free (out_free),
		.cmd      (cmd),
		.addr     (addr)
	);

	pgd_dpath #(.MAX_GRID(MAX_GRID)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.addr         (addr),
		.take         (take),
		.noise_sample (noise.noise_sample),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.cell_value   (result.cell_value),
		.cell_row     (result.cell_row),
		.cell_col     (result.cell_col),
		.last_cell    (result.last_cell),
		.out_free     (out_free)
	);

endmodule

@@ hdl/pgd_chk.sv @@
// port-level assertions for the periodic grid diffusion block, bound to the top level
module pgd_chk
	import pgd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [VAL_W-1:0] out_value,
	input logic [ROW_W-1:0] out_row,
	input logic [ROW_W-1:0] out_col,
	input logic             out_last
);

	// a sample keeps the block busy for the following cycle
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sample accepted straight after another");

	// no sample may enter while a run is still draining
	a_no_sample_mid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=> !in_ready)
		else $error("sample accepted before the last cell left");

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value)
			&& $stable(out_row) && $stable(out_col) && $stable(out_last)))
		else $error("result word changed under stall");

	// nothing to show right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight after reset");

endmodule

bind periodic_grid_diffusion_layers_core pgd_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (noise.valid),
	.in_ready  (noise.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.cell_value),
	.out_row   (result.cell_row),
	.out_col   (result.cell_col),
	.out_last  (result.last_cell)
);

@@ tb/tb.sv @@
// testbench for the periodic grid diffusion core: layered noise blending, smoothing and emission
module tb
	import pgd_pkg::*;
;

	localparam int MAX_GRID     = 8;
	localparam int CELLS_MAX    = MAX_GRID * MAX_GRID;
	localparam int RANDOM_ITEMS = 250;
	// blend, smoothing, copy-back, emission and fill of the largest grid, with margin
	localparam int SETTLE_CYCLES = 700;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic             last;
	} cell_word_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	pgd_noise_if noise_ch ();
	pgd_cell_if  cell_ch ();

	periodic_grid_diffusion_layers_core #(
		.MAX_GRID(MAX_GRID)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.noise(noise_ch),
		.result(cell_ch)
	);

	// grid model
	cfg_t             model_cfg;
	logic [VAL_W-1:0] grid_val [CELLS_MAX];
	logic [VAL_W-1:0] scratch_val [CELLS_MAX];
	bit               grid_known [CELLS_MAX];
	bit               scratch_known [CELLS_MAX];
	int unsigned      cell_pos;
	int unsigned      layer_pos;

	logic [VAL_W-1:0] pending_noise [$];
	cell_word_t       expected_cells [$];
	int               errors;

	int unsigned gap_left;
	int unsigned burst_left;
	int unsigned stall_pct;
	int unsigned stall_cnt;

	function automatic int unsigned side_of(logic [GS_W-1:0] gs);
		if (gs < MIN_SIDE) begin
			return MIN_SIDE;
		end
		if (gs > MAX_GRID) begin
			return MAX_GRID;
		end
		return gs;
	endfunction

	function automatic logic [VAL_W-1:0] round_q14(longint unsigned acc);
		longint unsigned v;
		v = (acc + 64'd32768) >> 16;
		return (v > TOP_Q14) ? TOP_Q14 : v[VAL_W-1:0];
	endfunction

	function automatic void model_reset();
		model_cfg.grid_size       = 4'd8;
		model_cfg.layer_count     = 16'd1;
		model_cfg.temporal_weight = '0;
		model_cfg.spatial_weight  = '0;
		for (int k = 0; k < CELLS_MAX; k++) begin
			grid_val[k]      = ONE_Q14;
			grid_known[k]    = 1'b1;
			scratch_val[k]   = '0;
			scratch_known[k] = 1'b0;
		end
		cell_pos  = 0;
		layer_pos = 0;
	endfunction

	// five-point smoothing with wraparound; the whole scratch is copied back
	function automatic void smooth_grid(int unsigned n);
		longint unsigned as_w;
		longint unsigned cw;
		longint unsigned nb;
		longint unsigned acc;
		int unsigned     up;
		int unsigned     dn;
		int unsigned     lf;
		int unsigned     rt;
		as_w = (model_cfg.spatial_weight > QUARTER_Q16) ? QUARTER_Q16 : model_cfg.spatial_weight;
		cw   = 64'd65536 - 4 * as_w;
		for (int unsigned r = 0; r < n; r++) begin
			up = (r == 0) ? n - 1 : r - 1;
			dn = (r + 1 == n) ? 0 : r + 1;
			for (int unsigned c = 0; c < n; c++) begin
				lf  = (c == 0) ? n - 1 : c - 1;
				rt  = (c + 1 == n) ? 0 : c + 1;
				nb  = 64'(grid_val[up * n + c]) + grid_val[dn * n + c]
					+ grid_val[r * n + lf] + grid_val[r * n + rt];
				acc = cw * grid_val[r * n + c] + as_w * nb;
				scratch_val[r * n + c]   = round_q14(acc);
				scratch_known[r * n + c] = 1'b1;
			end
		end
		grid_val   = scratch_val;
		grid_known = scratch_known;
	endfunction

	// one accepted noise word: blend, smooth at layer end, emit at run end
	function automatic void diffuse_sample(logic [VAL_W-1:0] sample);
		int unsigned     n;
		int unsigned     cells;
		int unsigned     layers;
		int unsigned     pos;
		longint unsigned keep_w;
		longint unsigned new_w;
		longint unsigned acc;
		cell_word_t      w;
		n      = side_of(model_cfg.grid_size);
		cells  = n * n;
		layers = (model_cfg.layer_count == 0) ? 1 : model_cfg.layer_count;
		pos    = (cell_pos < cells) ? cell_pos : 0;
		new_w  = (model_cfg.temporal_weight > ONE_Q16) ? ONE_Q16 : model_cfg.temporal_weight;
		keep_w = 64'd65536 - new_w;
		acc    = keep_w * grid_val[pos] + new_w * sample;
		grid_val[pos]   = round_q14(acc);
		grid_known[pos] = 1'b1;
		if (pos + 1 < cells) begin
			cell_pos = pos + 1;
			return;
		end
		cell_pos = 0;
		smooth_grid(n);
		if (layer_pos + 1 < layers) begin
			layer_pos++;
			return;
		end
		for (int unsigned k = 0; k < cells; k++) begin
			w.value = grid_val[k];
			w.row   = ROW_W'(k / n);
			w.col   = ROW_W'(k % n);
			w.last  = (k + 1 == cells);
			expected_cells.push_back(w);
		end
		for (int k = 0; k < CELLS_MAX; k++) begin
			grid_val[k]   = ONE_Q14;
			grid_known[k] = 1'b1;
		end
		layer_pos = 0;
	endfunction

	function automatic int unsigned items_to_run_end();
		int unsigned n;
		int unsigned cells;
		int unsigned layers;
		int unsigned p;
		n      = side_of(model_cfg.grid_size);
		cells  = n * n;
		layers = (model_cfg.layer_count == 0) ? 1 : model_cfg.layer_count;
		p      = (cell_pos < cells) ? cell_pos : 0;
		if (layer_pos + 1 >= layers) begin
			return cells - p;
		end
		return (layers - layer_pos) * cells - p;
	endfunction

	// a size is usable mid-run only if every cell it covers holds a written value
	function automatic bit size_usable(logic [GS_W-1:0] gs);
		int unsigned n;
		n = side_of(gs);
		for (int unsigned k = 0; k < n * n; k++) begin
			if (!grid_known[k]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [VAL_W-1:0] extreme_sample(int i);
		case (i % 4)
			0: return '0;
			1: return TOP_Q14;
			2: return ONE_Q14;
			default: return VAL_W'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] random_sample();
		if ($urandom_range(0, 7) == 0) begin
			return extreme_sample($urandom_range(0, 2));
		end
		return VAL_W'($urandom_range(0, 32767));
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GRID_SIZE:   model_cfg.grid_size       = value[GS_W-1:0];
			REG_LAYER_COUNT: model_cfg.layer_count     = value[LC_W-1:0];
			REG_TEMPORAL:    model_cfg.temporal_weight = value[TW_W-1:0];
			REG_SPATIAL:     model_cfg.spatial_weight  = value[SW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_samples(input int unsigned count, input bit extremes);
		for (int i = 0; i < count; i++) begin
			pending_noise.push_back(extremes ? extreme_sample(i) : random_sample());
		end
	endtask

	// sender holds off until every word is back, then lets any smoothing finish
	task automatic wait_drained();
		while (pending_noise.size() != 0 || expected_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		logic [GS_W-1:0] gs;
		int unsigned     r;
		int unsigned     n;
		if ($urandom_range(0, 1) == 1) begin
			r = $urandom_range(0, 19);
			if (r < 2) begin
				gs = GS_W'($urandom_range(0, 2));
			end else if (r < 4) begin
				gs = GS_W'($urandom_range(9, 15));
			end else if (r < 12) begin
				gs = GS_W'($urandom_range(3, 4));
			end else if (r < 17) begin
				gs = GS_W'($urandom_range(5, 7));
			end else begin
				gs = 4'd8;
			end
			if (size_usable(gs)) begin
				reg_write(REG_GRID_SIZE, APB_DW'(gs));
			end
		end
		n = side_of(model_cfg.grid_size);
		if ($urandom_range(0, 1) == 1) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				reg_write(REG_LAYER_COUNT, 1);
			end else if (r == 6) begin
				reg_write(REG_LAYER_COUNT, 0);
			end else begin
				reg_write(REG_LAYER_COUNT, (n <= 4) ? $urandom_range(2, 3) : 1);
			end
		end
		if ($urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 7))
				0: reg_write(REG_TEMPORAL, 0);
				1: reg_write(REG_TEMPORAL, ONE_Q16);
				2: reg_write(REG_TEMPORAL, $urandom_range(65537, 131071));
				default: reg_write(REG_TEMPORAL, $urandom_range(0, 65536));
			endcase
		end
		if ($urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 7))
				0: reg_write(REG_SPATIAL, 0);
				1: reg_write(REG_SPATIAL, QUARTER_Q16);
				2: reg_write(REG_SPATIAL, $urandom_range(16385, 32767));
				default: reg_write(REG_SPATIAL, $urandom_range(0, 16384));
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// noise driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_ch.valid        <= 1'b0;
			noise_ch.noise_sample <= '0;
			gap_left   = 0;
			burst_left = $urandom_range(1, 12);
		end else begin
			if (noise_ch.valid && noise_ch.ready) begin
				diffuse_sample(noise_ch.noise_sample);
				void'(pending_noise.pop_front());
			end
			if (noise_ch.valid && !noise_ch.ready) begin
				// word still offered, hold it
			end else if (gap_left != 0) begin
				gap_left--;
				noise_ch.valid <= 1'b0;
			end else if (pending_noise.size() != 0) begin
				noise_ch.valid        <= 1'b1;
				noise_ch.noise_sample <= pending_noise[0];
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				noise_ch.valid <= 1'b0;
			end
		end
	end

	// cell monitor: checks each cell word and redraws its stall rate when a countdown expires
	always @(posedge clk or negedge arst_n) begin : cell_mon
		cell_word_t want;
		if (!arst_n) begin
			cell_ch.ready <= 1'b0;
			stall_pct = 0;
			stall_cnt = 0;
		end else begin
			if (cell_ch.valid && cell_ch.ready) begin
				if (expected_cells.size() == 0) begin
					$error("unexpected cell word: row %0d col %0d value %0d",
						cell_ch.cell_row, cell_ch.cell_col, cell_ch.cell_value);
					errors++;
				end else begin
					want = expected_cells.pop_front();
					if (cell_ch.cell_value !== want.value) begin
						$error("cell_value: expected %0d, got %0d", want.value, cell_ch.cell_value);
						errors++;
					end
					if (cell_ch.cell_row !== want.row) begin
						$error("cell_row: expected %0d, got %0d", want.row, cell_ch.cell_row);
						errors++;
					end
					if (cell_ch.cell_col !== want.col) begin
						$error("cell_col: expected %0d, got %0d", want.col, cell_ch.cell_col);
						errors++;
					end
					if (cell_ch.last_cell !== want.last) begin
						$error("last_cell: expected %0d, got %0d", want.last, cell_ch.last_cell);
						errors++;
					end
				end
			end
			if (stall_cnt == 0) begin
				stall_cnt = 128;
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end else begin
				stall_cnt--;
			end
			cell_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		int unsigned random_fed;
		int unsigned count;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		errors     = 0;
		random_fed = 0;
		model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// full-size grid, stop part way into the layer
		reg_write(REG_LAYER_COUNT, 65535);
		reg_write(REG_TEMPORAL, ONE_Q16);
		reg_write(REG_SPATIAL, QUARTER_Q16);
		push_samples(9, 1'b1);
		wait_drained();
		// shrink below the reached position so the layer restarts, weights over range
		reg_write(REG_GRID_SIZE, 0);
		reg_write(REG_LAYER_COUNT, 2);
		reg_write(REG_TEMPORAL, 131071);
		reg_write(REG_SPATIAL, 32767);
		push_samples(9, 1'b1);
		wait_drained();
		// count dropped to zero after the first layer: next layer end emits
		reg_write(REG_LAYER_COUNT, 0);
		push_samples(9, 1'b1);
		wait_drained();

		while (random_fed < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				random_config();
			end
			if ($urandom_range(0, 4) != 0) begin
				count = items_to_run_end();
			end else begin
				count = $urandom_range(1, side_of(model_cfg.grid_size) ** 2);
			end
			push_samples(count, 1'b0);
			random_fed += count;
			wait_drained();
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
